// ===== sv/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg
// Shared constants and types of the frame reverse ping-pong unit.
// ----------------------------------------------------------------------------
package frp_pkg;

  // Pixels per bank and the widths that follow from it.
  localparam int unsigned FRAME_PIXELS = 65536;
  localparam int unsigned POS_W        = $clog2(FRAME_PIXELS);
  localparam int unsigned ADDR_W       = POS_W + 1;
  localparam int unsigned RAM_DEPTH    = 2 * FRAME_PIXELS;

  localparam int unsigned LANE_W       = 32;
  localparam int unsigned PIX_W        = 4 * LANE_W;
  localparam int unsigned CFG_W        = 17;

  localparam logic [POS_W-1:0] LAST_RESET = POS_W'(FRAME_PIXELS - 1);

  // Input item codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Per-item request from the sequencer to the bank memory and output side.
  typedef struct packed {
    logic              emit;
    logic              frame_end;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } frp_req_t;

endpackage

// ===== sv/frame_reverse_ping_pong_unit.sv =====
// ----------------------------------------------------------------------------
// frame_reverse_ping_pong_unit
// Reverses the pixel order of each frame through two ping-pong banks.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall_o is low. A load word writes its
// four-lane pixel into the filling bank; once a full frame is held in the
// other bank, each load also returns the mirrored pixel of that frame (load
// k returns held pixel N-1-k). Drain words read out the rest of the held
// frame in reverse, and loads seen during a drain are dropped. frame_end_o
// marks the last pixel of a frame. Rate: one word per cycle while not
// stalled; a result passes from the registered bank read to the output
// register, and the read stage holds while the output side is stalled.
// Both banks sit in one 131072 x 128 memory with one write
// and one read port; the read always targets the held bank and the write the
// filling bank, so the two never collide. Pixel memory is not cleared at
// reset and needs no clearing pass. Writing the frame size (cfg_data_i,
// clamped to 1..65536) restarts the stream; write it only while idle.
// ----------------------------------------------------------------------------
module frame_reverse_ping_pong_unit import frp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // frame size register
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [LANE_W-1:0] in_lane_0_i,
  input  logic [LANE_W-1:0] in_lane_1_i,
  input  logic [LANE_W-1:0] in_lane_2_i,
  input  logic [LANE_W-1:0] in_lane_3_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LANE_W-1:0] out_lane_0_o,
  output logic [LANE_W-1:0] out_lane_1_o,
  output logic [LANE_W-1:0] out_lane_2_o,
  output logic [LANE_W-1:0] out_lane_3_o,
  output logic              frame_end_o
);

  frp_req_t         req;
  logic             accept;
  logic             cfg_we;
  logic [PIX_W-1:0] rd_data;

  // read stage: valid and frame end travel next to the registered bank read
  logic             rd_valid_q, rd_valid_d;
  logic             rd_end_q;
  logic             rd_advance;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_end_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Stall only when both the read stage and the output register are full and
  // the output side is stalled; otherwise the read stage moves on this cycle.
  assign rd_advance = rd_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = rd_valid_q & out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  frp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .action_i   (action_i),
    .req_o      (req)
  );

  // Lane 0 sits in the low bits of the stored pixel.
  frp_ram #(
    .WIDTH  (PIX_W),
    .DEPTH  (RAM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (req.wr_en),
    .wr_addr_i (req.wr_addr),
    .wr_data_i ({in_lane_3_i, in_lane_2_i, in_lane_1_i, in_lane_0_i}),
    .rd_en_i   (req.emit),
    .rd_addr_i (req.rd_addr),
    .rd_data_o (rd_data)
  );

  // Fill the read stage on an emitting word, empty it when it moves on.
  always_comb begin
    rd_valid_d = rd_valid_q;
    if (req.emit) begin
      rd_valid_d = 1'b1;
    end else if (rd_advance) begin
      rd_valid_d = 1'b0;
    end
  end

  // Load the output register from the read stage, drop it once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (rd_advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.emit) begin
      rd_end_q <= req.frame_end;
    end
    if (rd_advance) begin
      out_pix_q <= rd_data;
      out_end_q <= rd_end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_lane_0_o = out_pix_q[LANE_W-1:0];
  assign out_lane_1_o = out_pix_q[2*LANE_W-1:LANE_W];
  assign out_lane_2_o = out_pix_q[3*LANE_W-1:2*LANE_W];
  assign out_lane_3_o = out_pix_q[4*LANE_W-1:3*LANE_W];
  assign frame_end_o  = out_end_q;

endmodule

// ===== sv/frp_ram.sv =====
// ----------------------------------------------------------------------------
// frp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module frp_ram #(
  parameter int unsigned WIDTH  = 128,
  parameter int unsigned DEPTH  = 131072,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/frp_ctrl.sv =====
// ----------------------------------------------------------------------------
// frp_ctrl
// Frame sequencer: frame size register, bank swap, load and drain positions.
// ----------------------------------------------------------------------------
module frp_ctrl import frp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             accept_i,
  input  logic             action_i,
  output frp_req_t         req_o
);

  logic [POS_W-1:0] last_q, last_d;
  logic             fill_bank_q, fill_bank_d;
  logic [POS_W-1:0] load_pos_q, load_pos_d;
  logic             held_q, held_d;
  logic             draining_q, draining_d;
  logic [POS_W-1:0] drain_pos_q, drain_pos_d;

  // Clamp the frame size to 1..FRAME_PIXELS and keep it as the last index.
  always_comb begin
    last_d = last_q;
    if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        last_d = '0;
      end else if (32'(cfg_data_i) > 32'(FRAME_PIXELS)) begin
        last_d = LAST_RESET;
      end else begin
        last_d = POS_W'(cfg_data_i - CFG_W'(1));
      end
    end
  end

  always_comb begin
    logic [POS_W-1:0] pos;
    pos         = '0;
    fill_bank_d = fill_bank_q;
    load_pos_d  = load_pos_q;
    held_d      = held_q;
    draining_d  = draining_q;
    drain_pos_d = drain_pos_q;
    req_o       = '0;

    if (cfg_we_i) begin
      fill_bank_d = 1'b0;
      load_pos_d  = '0;
      held_d      = 1'b0;
      draining_d  = 1'b0;
      drain_pos_d = '0;
    end else if (accept_i) begin
      if (action_i == ACT_DRAIN) begin
        if (draining_q || held_q) begin
          // continue from the pixels already mirrored out
          pos = draining_q ? drain_pos_q : load_pos_q;
          if (pos > last_q) begin
            fill_bank_d = 1'b0;
            load_pos_d  = '0;
            held_d      = 1'b0;
            draining_d  = 1'b0;
            drain_pos_d = '0;
          end else begin
            req_o.emit      = 1'b1;
            req_o.frame_end = (pos == last_q);
            req_o.rd_addr   = {~fill_bank_q, last_q - pos};
            if (pos == last_q) begin
              load_pos_d  = '0;
              held_d      = 1'b0;
              draining_d  = 1'b0;
              drain_pos_d = '0;
            end else begin
              draining_d  = 1'b1;
              drain_pos_d = pos + POS_W'(1);
            end
          end
        end
      end else if (!draining_q) begin
        pos = (load_pos_q > last_q) ? '0 : load_pos_q;
        req_o.emit      = held_q;
        req_o.frame_end = (pos == last_q);
        req_o.rd_addr   = {~fill_bank_q, last_q - pos};
        req_o.wr_en     = 1'b1;
        req_o.wr_addr   = {fill_bank_q, pos};
        if (pos == last_q) begin
          load_pos_d  = '0;
          fill_bank_d = ~fill_bank_q;
          held_d      = 1'b1;
        end else begin
          load_pos_d  = pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= LAST_RESET;
      fill_bank_q <= 1'b0;
      load_pos_q  <= '0;
      held_q      <= 1'b0;
      draining_q  <= 1'b0;
      drain_pos_q <= '0;
    end else begin
      last_q      <= last_d;
      fill_bank_q <= fill_bank_d;
      load_pos_q  <= load_pos_d;
      held_q      <= held_d;
      draining_q  <= draining_d;
      drain_pos_q <= drain_pos_d;
    end
  end

endmodule
